### hw/rtl/tlvrs_pkg.sv
// Types and constants shared by the record splitter modules.
package tlvrs_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 24;

  typedef enum logic [2:0] {
    PH_ID   = 3'd0,
    PH_LEN0 = 3'd1,
    PH_LEN1 = 3'd2,
    PH_LEN2 = 3'd3,
    PH_DATA = 3'd4
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [ByteW-1:0] record_id;
    logic [ByteW-1:0] payload_byte;
    logic [LenW-1:0]  payload_offset;
    logic             empty_record;
    logic             last_of_record;
  } out_item_t;

endpackage

### hw/rtl/tlvrs_stream_if.sv
// Valid/ready stream interface carrying one payload item per transfer.
interface tlvrs_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/tlvrs_parser.sv
// Input register and record header/payload state machine.
module tlvrs_parser import tlvrs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  tlvrs_stream_if.sink        in_i,
  output logic                res_valid_o,
  output out_item_t           res_o,
  input  logic                res_ready_i
);

  logic             s1_valid_q, s1_valid_d;
  logic [ByteW-1:0] s1_byte_q;
  logic             s1_fire;

  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] id_q, id_d;
  logic [LenW-1:0]  rem_q, rem_d;
  logic [LenW-1:0]  pos_q, pos_d;
  logic [LenW-1:0]  len_full;
  logic             is_last;

  assign in_i.ready = !s1_valid_q || res_ready_i;
  assign s1_fire    = s1_valid_q && res_ready_i;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_i.ready) begin
      s1_valid_d = in_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_byte_q <= in_i.payload.data_byte;
    end
  end

  assign len_full = {rem_q[LenW-1:ByteW], s1_byte_q};
  assign is_last  = (rem_q[LenW-1:1] == '0);

  always_comb begin
    phase_d     = phase_q;
    id_d        = id_q;
    rem_d       = rem_q;
    pos_d       = pos_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.record_id = id_q;
    case (phase_q)
      PH_LEN0: begin
        rem_d   = {s1_byte_q, {(LenW-ByteW){1'b0}}};
        phase_d = PH_LEN1;
      end
      PH_LEN1: begin
        rem_d   = {rem_q[LenW-1:2*ByteW], s1_byte_q, {ByteW{1'b0}}};
        phase_d = PH_LEN2;
      end
      PH_LEN2: begin
        rem_d = len_full;
        pos_d = '0;
        if (len_full == '0) begin
          res_valid_o          = s1_valid_q;
          res_o.empty_record   = 1'b1;
          res_o.last_of_record = 1'b1;
          phase_d              = PH_ID;
        end else begin
          phase_d = PH_DATA;
        end
      end
      PH_DATA: begin
        res_valid_o          = s1_valid_q;
        res_o.payload_byte   = s1_byte_q;
        res_o.payload_offset = pos_q;
        res_o.last_of_record = is_last;
        rem_d                = rem_q - LenW'(1);
        pos_d                = pos_q + LenW'(1);
        if (is_last) begin
          rem_d   = '0;
          phase_d = PH_ID;
        end
      end
      default: begin
        id_d    = s1_byte_q;
        rem_d   = '0;
        pos_d   = '0;
        phase_d = PH_LEN0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_ID;
      id_q    <= '0;
      rem_q   <= '0;
      pos_q   <= '0;
    end else if (s1_fire) begin
      phase_q <= phase_d;
      id_q    <= id_d;
      rem_q   <= rem_d;
      pos_q   <= pos_d;
    end
  end

endmodule

### hw/rtl/tlvrs_out_reg.sv
// Result register driving the output channel.
module tlvrs_out_reg import tlvrs_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           res_valid_i,
  input  out_item_t      res_i,
  output logic           res_ready_o,
  tlvrs_stream_if.source out_o
);

  logic      valid_q, valid_d;
  out_item_t data_q;
  logic      load;

  assign res_ready_o = !valid_q || out_o.ready;
  assign load        = res_valid_i && res_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (res_ready_o) begin
      valid_d = res_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= res_i;
    end
  end

  assign out_o.valid   = valid_q;
  assign out_o.payload = data_q;

endmodule

### hw/rtl/tlv_record_splitter.sv
// Top level of the TLV record splitter.
// Input channel in_i takes one byte of the record stream per transfer. Each record is
// an identifier byte, a 24-bit big-endian length and that many payload bytes.
// Output channel out_o gives one result per payload byte: identifier, the byte, its
// offset in the payload and a last flag; a zero-length record gives one result with
// empty_record and last_of_record set, on its last length byte; other header bytes give no result.
// A byte taken on in_i passes the input register, then the result register, to out_o.
// Throughput: one byte per cycle while out_o is not stalling; the header/payload state advances once per byte.
// Reset clears the parser state to expect an identifier byte and drops both
// registers' valid flags.
// When out_o stalls with a result held, the input register holds its byte and in_i
// deasserts ready once that register is full; no transfer is lost or repeated.
module tlv_record_splitter import tlvrs_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  tlvrs_stream_if.sink   in_i,
  tlvrs_stream_if.source out_o
);

  logic      res_valid;
  logic      res_ready;
  out_item_t res;

  tlvrs_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  tlvrs_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .res_ready_o (res_ready),
    .out_o       (out_o)
  );

  // Input only stalls behind a stalled output
  a_in_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && !in_i.ready |-> out_o.valid && !out_o.ready)
    else $error("input stalled while output free");

  a_empty_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.payload.empty_record |->
      out_o.payload.last_of_record && out_o.payload.payload_offset == '0
      && out_o.payload.payload_byte == '0)
    else $error("empty record result malformed");

  a_res_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |-> out_o.valid && !out_o.ready)
    else $error("result refused with output free");

endmodule

### verif/tb_tlv_record_splitter.sv
// Testbench for tlv_record_splitter: directed and random record streams checked against a predictor.
`timescale 1ns / 1ps

module tb_tlv_record_splitter;
  import tlvrs_pkg::*;

  localparam int DirectedRows = 22;
  localparam int RandomBytes  = 1350;
  localparam int IdleLimit    = 200;
  localparam int DrainCycles  = 8;

  typedef struct {
    logic [ByteW-1:0] data;
    bit               given;
    out_item_t        result;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  tlvrs_stream_if #(.payload_t(in_item_t))  in_if ();
  tlvrs_stream_if #(.payload_t(out_item_t)) out_if ();

  tlv_record_splitter u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state
  phase_e            parse_phase = PH_ID;
  logic [ByteW-1:0]  cur_id      = '0;
  logic [LenW-1:0]   len_left    = '0;
  logic [LenW-1:0]   next_offset = '0;

  out_item_t expected_payload_q[$];
  int        err_count  = 0;
  int        bytes_fed  = 0;
  int        out_stall  = 0;
  int        idle_count = 0;
  bit        calm       = 1'b0;

  stim_row_t directed_rows [DirectedRows] = '{
    // empty record straight after reset
    '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
    '{8'h00, 1'b1, {8'h00, 8'h00, 24'h000000, 1'b1, 1'b1}},
    // single byte record, all ones
    '{8'hFF, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h01, 1'b0, '0},
    '{8'hFF, 1'b1, {8'hFF, 8'hFF, 24'h000000, 1'b0, 1'b1}},
    '{8'hA5, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h03, 1'b0, '0},
    '{8'h00, 1'b0, '0}, '{8'h7F, 1'b0, '0}, '{8'h80, 1'b0, '0},
    '{8'h5A, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h02, 1'b0, '0},
    '{8'h55, 1'b0, '0}, '{8'hAA, 1'b0, '0}
  };

  function automatic bit split_byte(input logic [ByteW-1:0] b, output out_item_t res);
    bit hit;
    hit = 1'b0;
    res = '0;
    case (parse_phase)
      PH_LEN0: begin
        len_left    = {b, 16'h0000};
        parse_phase = PH_LEN1;
      end
      PH_LEN1: begin
        len_left[15:8] = b;
        parse_phase    = PH_LEN2;
      end
      PH_LEN2: begin
        len_left[7:0] = b;
        next_offset   = '0;
        if (len_left == '0) begin
          res.record_id      = cur_id;
          res.empty_record   = 1'b1;
          res.last_of_record = 1'b1;
          hit                = 1'b1;
          parse_phase        = PH_ID;
        end else begin
          parse_phase = PH_DATA;
        end
      end
      PH_DATA: begin
        res.record_id      = cur_id;
        res.payload_byte   = b;
        res.payload_offset = next_offset;
        res.last_of_record = (len_left <= 1);
        hit                = 1'b1;
        len_left           = len_left - 1'b1;
        next_offset        = next_offset + 1'b1;
        if (res.last_of_record) begin
          len_left    = '0;
          parse_phase = PH_ID;
        end
      end
      default: begin
        // identifier byte; unused phase codes fall here as well
        cur_id      = b;
        len_left    = '0;
        next_offset = '0;
        parse_phase = PH_LEN0;
      end
    endcase
    return hit;
  endfunction

  task automatic check_field(input string name, input logic [LenW-1:0] exp_v,
                             input logic [LenW-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      err_count++;
    end
  endtask

  task automatic check_payload_result(input out_item_t got);
    out_item_t want;
    if (expected_payload_q.size() == 0) begin
      $error("unexpected result: id 0x%0h byte 0x%0h offset %0d", got.record_id,
             got.payload_byte, got.payload_offset);
      err_count++;
    end else begin
      want = expected_payload_q.pop_front();
      check_field("record_id", LenW'(want.record_id), LenW'(got.record_id));
      check_field("payload_byte", LenW'(want.payload_byte), LenW'(got.payload_byte));
      check_field("payload_offset", want.payload_offset, got.payload_offset);
      check_field("empty_record", LenW'(want.empty_record), LenW'(got.empty_record));
      check_field("last_of_record", LenW'(want.last_of_record),
                  LenW'(got.last_of_record));
    end
  endtask

  task automatic feed_byte(input logic [ByteW-1:0] b, input bit given = 1'b0,
                           input out_item_t given_res = '0);
    int        gap;
    bit        hit;
    out_item_t res;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid             <= 1'b1;
    in_if.payload.data_byte <= b;
    do @(posedge clk_i); while (!in_if.ready);
    bytes_fed++;
    hit = split_byte(b, res);
    if (given) expected_payload_q = {expected_payload_q, given_res};
    else if (hit) expected_payload_q = {expected_payload_q, res};
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (expected_payload_q.size() != 0);
  endtask

  task automatic feed_record(input logic [ByteW-1:0] id, input logic [LenW-1:0] len,
                             input int pause_after);
    feed_byte(id);
    feed_byte(len[23:16]);
    feed_byte(len[15:8]);
    feed_byte(len[7:0]);
    for (int i = 0; i < len; i++) begin
      // stream stops mid-record; block must sit waiting for the rest
      if (i == pause_after) wait_drained();
      feed_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // result side: random stall after each transfer, none while calm
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        check_payload_result(out_if.payload);
        out_stall = calm ? 0 : $urandom_range(0, 3);
      end
      if (out_stall > 0) begin
        out_if.ready <= 1'b0;
        out_stall--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_count = 0;
      end else begin
        idle_count++;
      end
      if (idle_count >= IdleLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int rec;
    int pick;
    int len;
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.payload = '0;
    out_if.ready  = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      feed_byte(directed_rows[i].data, directed_rows[i].given, directed_rows[i].result);
    end

    rec = 0;
    while (bytes_fed < DirectedRows + RandomBytes) begin
      calm = (rec >= 30 && rec < 45);
      pick = $urandom_range(0, 15);
      if (rec == 10) len = 24'h000102;
      else if (rec == 11) len = 24'h000081;
      else if (rec == 20) len = 6;
      else if (pick == 0) len = 0;
      else if (pick == 1) len = $urandom_range(100, 300);
      else len = $urandom_range(1, 12);
      feed_record(8'($urandom_range(0, 255)), LenW'(len), (rec == 20) ? 3 : -1);
      rec++;
    end
    calm = 1'b0;

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### tlv_record_splitter.f
hw/rtl/tlvrs_pkg.sv
hw/rtl/tlvrs_stream_if.sv
hw/rtl/tlvrs_parser.sv
hw/rtl/tlvrs_out_reg.sv
hw/rtl/tlv_record_splitter.sv
verif/tb_tlv_record_splitter.sv
